// ===== hw/rtl/aph_pkg.sv =====
// Shared constants, types and helpers of the autopilot hold block.
`timescale 1ns / 1ps
`default_nettype none

package aph_pkg;

  // Angle arithmetic width: holds any difference of two 16-bit angles
  localparam int ANG_W = 18;
  localparam logic signed [ANG_W-1:0] HALF_TURN = 18'sd23040;
  localparam logic signed [ANG_W-1:0] FULL_TURN = 18'sd46080;

  // Fixed glide-slope band of 10 degrees
  localparam logic [14:0] SLOPE_BAND = 15'd1280;

  // Quotient bits of the band scaling divide
  localparam int DIV_STEPS = 15;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE             = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEADING   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROLL_OUT_BAND    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ROLL         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_AILERON      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ROLL_SMOOTH_BAND = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_SLOPE     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ELEVATOR     = 3'd7;

  // Mode codes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_HEADING = 2'd1;
  localparam logic [1:0] MODE_GLIDE   = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  // Surface codes
  localparam logic [1:0] SURF_NONE     = 2'd0;
  localparam logic [1:0] SURF_AILERON  = 2'd1;
  localparam logic [1:0] SURF_ELEVATOR = 2'd2;

  // Status codes
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_INVALID = 1'b1;

  // Per-item tag that rides along the shaping pipelines.
  // aux: roll angle before the first shaper, finished elevator command after it.
  typedef struct packed {
    logic [1:0]         surface;
    logic               status;
    logic signed [15:0] aux;
  } side_t;

  // One stage of the restoring divider plus the final-select context
  typedef struct packed {
    logic [15:0] rem;
    logic [14:0] low;
    logic [14:0] quo;
    logic [15:0] den;
    logic [14:0] maxv;
    logic        neg;
    logic        sat;
    logic        zero;
    side_t       side;
  } div_stage_t;

  // One-step wrap into (-180, 180] degrees
  function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] a1;
    a1 = (a > HALF_TURN) ? a - FULL_TURN : a;
    return (a1 <= -HALF_TURN) ? a1 + FULL_TURN : a1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aph_if.sv =====
// Request channel interfaces for sensor ticks and control results.
`timescale 1ns / 1ps
`default_nettype none

interface aph_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        heading;
  logic signed [15:0] roll;
  logic signed [15:0] pitch;

  modport source(output valid, heading, roll, pitch, input ready);
  modport sink(input valid, heading, roll, pitch, output ready);
endinterface

interface aph_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         surface;
  logic signed [15:0] command;
  logic               status;

  modport source(output valid, surface, command, status, input ready);
  modport sink(input valid, surface, command, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/aph_shape.sv =====
// Saturated linear map y = round(x * maxv / band), pipelined over 19 stages.
`timescale 1ns / 1ps
`default_nettype none

module aph_shape (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [aph_pkg::ANG_W-1:0] x,
  input  logic [14:0]                      band,
  input  logic [14:0]                      maxv,
  input  aph_pkg::side_t                   side_in,
  output logic                             out_valid,
  output logic signed [15:0]               y,
  output aph_pkg::side_t                   side_out
);
  import aph_pkg::*;

  // Stage A: magnitude, sign and band flags
  logic [ANG_W-1:0] ax;
  logic             a_valid;
  logic [14:0]      a_ax;
  logic [14:0]      a_band;
  logic [14:0]      a_maxv;
  logic             a_neg;
  logic             a_sat;
  logic             a_zero;
  side_t            a_side;

  // Stage B: product
  logic             b_valid;
  logic [29:0]      b_prod;
  logic [14:0]      b_band;
  logic [14:0]      b_maxv;
  logic             b_neg;
  logic             b_sat;
  logic             b_zero;
  side_t            b_side;

  // Stage C and divider stages
  logic [31:0]      num;
  logic             d_valid [DIV_STEPS+1];
  div_stage_t       d_stg   [DIV_STEPS+1];
  div_stage_t       d_nxt   [DIV_STEPS];
  logic [16:0]      trial;
  logic [14:0]      mag;

  assign ax = x[ANG_W-1] ? ANG_W'(-x) : ANG_W'(x);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ax   <= ax[14:0];
      a_band <= band;
      a_maxv <= maxv;
      a_neg  <= x[ANG_W-1];
      a_sat  <= ax > {3'b000, band};
      a_zero <= band == 15'd0;
      a_side <= side_in;
    end
  end

  // Stage B: magnitude times full-scale
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod <= 30'(a_ax) * 30'(a_maxv);
      b_band <= a_band;
      b_maxv <= a_maxv;
      b_neg  <= a_neg;
      b_sat  <= a_sat;
      b_zero <= a_zero;
      b_side <= a_side;
    end
  end

  // Stage C: rounding numerator 2*p + band over 2*band
  assign num = {1'b0, b_prod, 1'b0} + {17'd0, b_band};

  // Restoring divide, one quotient bit per stage
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      d_nxt[k]     = d_stg[k];
      d_nxt[k].low = {d_stg[k].low[13:0], 1'b0};
      trial        = {d_stg[k].rem, d_stg[k].low[14]};
      if (trial >= {1'b0, d_stg[k].den}) begin
        d_nxt[k].rem = 16'(trial - {1'b0, d_stg[k].den});
        d_nxt[k].quo = {d_stg[k].quo[13:0], 1'b1};
      end else begin
        d_nxt[k].rem = trial[15:0];
        d_nxt[k].quo = {d_stg[k].quo[13:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        d_valid[k] <= 1'b0;
      end
    end else if (en) begin
      d_valid[0] <= b_valid;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        d_valid[k] <= d_valid[k-1];
      end
    end
  end

  // Quotient fits 15 bits inside the band, so the top bits start below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      d_stg[0].rem  <= num[30:15];
      d_stg[0].low  <= num[14:0];
      d_stg[0].quo  <= '0;
      d_stg[0].den  <= {b_band, 1'b0};
      d_stg[0].maxv <= b_maxv;
      d_stg[0].neg  <= b_neg;
      d_stg[0].sat  <= b_sat;
      d_stg[0].zero <= b_zero;
      d_stg[0].side <= b_side;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        d_stg[k] <= d_nxt[k-1];
      end
    end
  end

  // Stage E: saturate, zero band, restore sign
  always_comb begin
    if (d_stg[DIV_STEPS].sat) begin
      mag = d_stg[DIV_STEPS].maxv;
    end else if (d_stg[DIV_STEPS].zero) begin
      mag = '0;
    end else begin
      mag = d_stg[DIV_STEPS].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y        <= d_stg[DIV_STEPS].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      side_out <= d_stg[DIV_STEPS].side;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/autopilot_saturated_hold.sv =====
// Autopilot hold: heading/roll to aileron or pitch to elevator, saturated linear laws.
// Throughput: one request per cycle while no result is held; two chained 19-stage
//   shapers, each with a 15-stage restoring divider, set the depth.
// A held result freezes the whole pipeline, so input ready drops with it.
// Reset (rst, synchronous) empties the pipeline and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module autopilot_saturated_hold (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [aph_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [aph_pkg::CFG_DATA_W-1:0]   cfg_data,
  aph_in_if.sink                           sample,
  aph_out_if.source                        result
);
  import aph_pkg::*;

  // Configuration registers
  logic [1:0]         mode;
  logic [15:0]        target_heading;
  logic [14:0]        roll_out_band;
  logic [14:0]        max_roll;
  logic [14:0]        max_aileron;
  logic [14:0]        roll_smooth_band;
  logic signed [14:0] target_slope;
  logic [14:0]        max_elevator;

  logic en;

  // Stage 0: input register
  logic               s0_valid;
  logic [15:0]        s0_heading;
  logic signed [15:0] s0_roll;
  logic signed [15:0] s0_pitch;

  // Stage 1: wrapped error for the first shaper
  logic signed [ANG_W-1:0] head_err;
  logic signed [ANG_W-1:0] slope_err;
  logic signed [ANG_W-1:0] s1_x_next;
  logic [14:0]             s1_band_next;
  logic [14:0]             s1_maxv_next;
  side_t                   s1_side_next;
  logic                    s1_valid;
  logic signed [ANG_W-1:0] s1_x;
  logic [14:0]             s1_band;
  logic [14:0]             s1_maxv;
  side_t                   s1_side;

  // First shaper output
  logic               h_valid;
  logic signed [15:0] h_y;
  side_t              h_side;

  // Mid stage: roll error for the second shaper
  logic signed [ANG_W-1:0] roll_err;
  logic signed [ANG_W-1:0] m_x_next;
  logic [14:0]             m_band_next;
  logic [14:0]             m_maxv_next;
  side_t                   m_side_next;
  logic                    m_valid;
  logic signed [ANG_W-1:0] m_x;
  logic [14:0]             m_band;
  logic [14:0]             m_maxv;
  side_t                   m_side;

  // Second shaper output
  logic               r_valid;
  logic signed [15:0] r_y;
  side_t              r_side;

  logic signed [15:0] command_next;

  // Whole pipeline advances unless a result is held
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_OFF;
      target_heading   <= 16'd0;
      roll_out_band    <= 15'd3840;
      max_roll         <= 15'd896;
      max_aileron      <= 15'd3277;
      roll_smooth_band <= 15'd1280;
      target_slope     <= 15'sd0;
      max_elevator     <= 15'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:             mode             <= cfg_data[1:0];
        REG_TARGET_HEADING:   target_heading   <= cfg_data;
        REG_ROLL_OUT_BAND:    roll_out_band    <= cfg_data[14:0];
        REG_MAX_ROLL:         max_roll         <= cfg_data[14:0];
        REG_MAX_AILERON:      max_aileron      <= cfg_data[14:0];
        REG_ROLL_SMOOTH_BAND: roll_smooth_band <= cfg_data[14:0];
        REG_TARGET_SLOPE:     target_slope     <= $signed(cfg_data[14:0]);
        REG_MAX_ELEVATOR:     max_elevator     <= cfg_data[14:0];
      endcase
    end
  end

  // Stage 0
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_heading <= sample.heading;
      s0_roll    <= sample.roll;
      s0_pitch   <= sample.pitch;
    end
  end

  // Stage 1: heading or slope error, chosen by mode
  assign head_err  = wrap_angle($signed({2'b00, target_heading}) - $signed({2'b00, s0_heading}));
  assign slope_err = wrap_angle(ANG_W'(target_slope) - ANG_W'(s0_pitch));

  always_comb begin
    s1_side_next.aux = s0_roll;
    s1_x_next        = '0;
    s1_band_next     = roll_out_band;
    s1_maxv_next     = max_roll;
    unique case (mode)
      MODE_OFF: begin
        s1_side_next.surface = SURF_NONE;
        s1_side_next.status  = STAT_OK;
      end
      MODE_HEADING: begin
        s1_side_next.surface = SURF_AILERON;
        s1_side_next.status  = STAT_OK;
        s1_x_next            = head_err;
      end
      MODE_GLIDE: begin
        s1_side_next.surface = SURF_ELEVATOR;
        s1_side_next.status  = STAT_OK;
        s1_x_next            = slope_err;
        s1_band_next         = SLOPE_BAND;
        s1_maxv_next         = max_elevator;
      end
      MODE_INVALID: begin
        s1_side_next.surface = SURF_NONE;
        s1_side_next.status  = STAT_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x    <= s1_x_next;
      s1_band <= s1_band_next;
      s1_maxv <= s1_maxv_next;
      s1_side <= s1_side_next;
    end
  end

  // Target roll, or finished elevator command
  aph_shape u_shape_head (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s1_valid),
    .x        (s1_x),
    .band     (s1_band),
    .maxv     (s1_maxv),
    .side_in  (s1_side),
    .out_valid(h_valid),
    .y        (h_y),
    .side_out (h_side)
  );

  // Mid stage: roll error; elevator command parks in the tag
  assign roll_err = wrap_angle(ANG_W'(h_y) - ANG_W'(h_side.aux));

  always_comb begin
    m_side_next = h_side;
    if (h_side.surface == SURF_AILERON) begin
      m_x_next    = roll_err;
      m_band_next = roll_smooth_band;
      m_maxv_next = max_aileron;
    end else begin
      m_x_next        = '0;
      m_band_next     = roll_smooth_band;
      m_maxv_next     = '0;
      m_side_next.aux = h_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_x    <= m_x_next;
      m_band <= m_band_next;
      m_maxv <= m_maxv_next;
      m_side <= m_side_next;
    end
  end

  // Aileron command
  aph_shape u_shape_roll (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .x        (m_x),
    .band     (m_band),
    .maxv     (m_maxv),
    .side_in  (m_side),
    .out_valid(r_valid),
    .y        (r_y),
    .side_out (r_side)
  );

  // Output register; magnitudes never exceed 32767, so no clamp is needed
  always_comb begin
    unique case (r_side.surface)
      SURF_AILERON:  command_next = r_y;
      SURF_ELEVATOR: command_next = r_side.aux;
      default:       command_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.surface <= r_side.surface;
      result.command <= command_next;
      result.status  <= r_side.status;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aph_check.sv =====
// Port-level checker for the autopilot hold block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module aph_check (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [1:0]         res_surface,
  input logic signed [15:0] res_command,
  input logic               res_status
);
  import aph_pkg::*;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A held result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_surface)
      && $stable(res_command) && $stable(res_status))
    else $error("held result changed");

  // A held result freezes the pipeline and blocks new requests
  a_block: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !in_ready)
    else $error("request taken while result held");

  // Invalid mode carries no command
  a_invalid: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == STAT_INVALID |-> res_surface == SURF_NONE && res_command == 16'sd0)
    else $error("invalid mode with command");

  // Shaped commands are symmetric, so the most negative code never appears
  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_command != 16'sh8000)
    else $error("command out of symmetric range");

endmodule

bind autopilot_saturated_hold aph_check u_aph_check (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (sample.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_surface(result.surface),
  .res_command(result.command),
  .res_status (result.status)
);

`default_nettype wire

// ===== tb/tb_autopilot_saturated_hold.sv =====
// Self-checking testbench for the autopilot saturated hold block.
`timescale 1ns / 1ps

module tb_autopilot_saturated_hold;
  import aph_pkg::*;

  // Angle and command limits used by the predictor
  localparam longint ANG_HALF   = 23040;
  localparam longint ANG_FULL   = 46080;
  localparam longint GLIDE_BAND = 1280;
  localparam longint CMD_MAX    = 32767;
  localparam longint CMD_MIN    = -32768;

  // Receiver hold-off that backs the pipeline up into the input
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 600;
  localparam int RANDOM_TICKS = 1500;

  // Register presets of the directed table
  localparam int P_OFF       = 0;
  localparam int P_INVALID   = 1;
  localparam int P_HEAD      = 2;
  localparam int P_HEAD_EXT  = 3;
  localparam int P_ZERO_BAND = 4;
  localparam int P_GLIDE     = 5;
  localparam int P_GLIDE_NEG = 6;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        target_heading;
    logic [14:0]        roll_out_band;
    logic [14:0]        max_roll;
    logic [14:0]        max_aileron;
    logic [14:0]        roll_smooth_band;
    logic signed [14:0] target_slope;
    logic [14:0]        max_elevator;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        heading;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } tick_t;

  typedef struct packed {
    logic [1:0]         surface;
    logic signed [15:0] command;
    logic               status;
  } ctl_t;

  typedef struct {
    int    preset;
    tick_t tick;
    bit    given;
    ctl_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  aph_in_if  sample_ch ();
  aph_out_if result_ch ();

  autopilot_saturated_hold u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample(sample_ch),
    .result(result_ch)
  );

  cfg_t     ap_cfg;
  cfg_t     presets [7];
  dir_row_t dir_rows [$];
  ctl_t     pending_cmds [$];
  bit       tx_calm = 1'b0;
  bit       rx_calm = 1'b0;
  int       mismatches = 0;
  int       results_checked = 0;
  int       settings_loaded = 0;
  int       ticks_by_mode [4] = '{0, 0, 0, 0};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One-step wrap into (-180, 180] degrees
  function automatic longint fold_angle(longint a);
    if (a > ANG_HALF) a -= ANG_FULL;
    if (a <= -ANG_HALF) a += ANG_FULL;
    return a;
  endfunction

  // Saturate outside the band, else scale with rounding half away from zero
  function automatic longint limit_map(longint x, longint band, longint top);
    longint mag, q;
    mag = (x < 0) ? -x : x;
    if (mag > band) return (x < 0) ? -top : top;
    if (band == 0) return 0;
    q = (2 * mag * top + band) / (2 * band);
    return (x < 0) ? -q : q;
  endfunction

  function automatic ctl_t predict_hold(cfg_t c, tick_t t);
    longint err, roll_goal, deflect;
    ctl_t r;
    r.surface = SURF_NONE;
    r.status  = STAT_OK;
    deflect   = 0;
    case (c.mode)
      MODE_HEADING: begin
        err = fold_angle(longint'(c.target_heading) - longint'(t.heading));
        roll_goal = limit_map(err, c.roll_out_band, c.max_roll);
        err = fold_angle(roll_goal - longint'($signed(t.roll)));
        deflect = limit_map(err, c.roll_smooth_band, c.max_aileron);
        r.surface = SURF_AILERON;
      end
      MODE_GLIDE: begin
        err = fold_angle(longint'($signed(c.target_slope)) - longint'($signed(t.pitch)));
        deflect = limit_map(err, GLIDE_BAND, c.max_elevator);
        r.surface = SURF_ELEVATOR;
      end
      MODE_INVALID: r.status = STAT_INVALID;
      default: ;
    endcase
    if (deflect > CMD_MAX) deflect = CMD_MAX;
    if (deflect < CMD_MIN) deflect = CMD_MIN;
    r.command = deflect[15:0];
    return r;
  endfunction

  function automatic cfg_t make_cfg(int m, int th, int rob, int mr, int ma, int rsb,
                                    int ts, int me);
    cfg_t c;
    c.mode             = m[1:0];
    c.target_heading   = th[15:0];
    c.roll_out_band    = rob[14:0];
    c.max_roll         = mr[14:0];
    c.max_aileron      = ma[14:0];
    c.roll_smooth_band = rsb[14:0];
    c.target_slope     = ts[14:0];
    c.max_elevator     = me[14:0];
    return c;
  endfunction

  function automatic void add_row(int preset, int h, int r, int p, bit given,
                                  logic [1:0] surf, int cmd, logic stat);
    dir_row_t row;
    row.preset       = preset;
    row.tick.heading = h[15:0];
    row.tick.roll    = r[15:0];
    row.tick.pitch   = p[15:0];
    row.given        = given;
    row.want.surface = surf;
    row.want.command = cmd[15:0];
    row.want.status  = stat;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [14:0] pick_band();
    case ($urandom_range(9, 0))
      0:       return 15'd0;
      1:       return 15'd1;
      2:       return 15'd23040;
      3:       return 15'($urandom);
      4, 5:    return 15'($urandom_range(64, 1));
      default: return 15'($urandom_range(23040, 1));
    endcase
  endfunction

  function automatic logic [14:0] pick_max(int lim);
    case ($urandom_range(5, 0))
      0:       return 15'd0;
      1:       return lim[14:0];
      2:       return 15'd32767;
      default: return 15'($urandom_range(lim, 0));
    endcase
  endfunction

  // Extremes first, then random settings weighted toward the two hold modes
  function automatic cfg_t random_settings(int phase);
    cfg_t c;
    int pick;
    case (phase)
      0: return make_cfg(MODE_HEADING, 46079, 23040, 23040, 32767, 23040, 11520, 32767);
      1: return make_cfg(MODE_GLIDE, 46079, 23040, 23040, 32767, 23040, 11520, 32767);
      2: return make_cfg(MODE_HEADING, 0, 1, 0, 32767, 1, -11520, 0);
      3: return make_cfg(MODE_GLIDE, 0, 1, 0, 0, 1, -11520, 0);
      default: ;
    endcase
    pick = $urandom_range(19, 0);
    c.mode = (pick < 8) ? MODE_HEADING : (pick < 15) ? MODE_GLIDE :
             (pick < 18) ? MODE_OFF : MODE_INVALID;
    c.target_heading = ($urandom_range(9, 0) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(46079, 0));
    c.roll_out_band    = pick_band();
    c.roll_smooth_band = pick_band();
    c.max_roll         = pick_max(23040);
    c.max_aileron      = pick_max(32767);
    c.max_elevator     = pick_max(32767);
    c.target_slope = ($urandom_range(9, 0) == 0) ? 15'($urandom)
                                                : 15'($urandom_range(23040, 0) - 11520);
    return c;
  endfunction

  // Angles near the band edges of both shapers half the time, else in range or full-width noise
  function automatic tick_t random_tick(cfg_t c);
    tick_t t;
    longint b, roll_goal;
    case ($urandom_range(3, 0))
      0: t.heading = 16'($urandom);
      1: t.heading = 16'($urandom_range(46079, 0));
      default: begin
        b = c.roll_out_band;
        t.heading = 16'(longint'(c.target_heading) + longint'($urandom_range(2 * b + 4, 0))
                        - (b + 2));
      end
    endcase
    roll_goal = limit_map(fold_angle(longint'(c.target_heading) - longint'(t.heading)),
                          c.roll_out_band, c.max_roll);
    case ($urandom_range(3, 0))
      0: t.roll = 16'($urandom);
      1: t.roll = 16'($urandom_range(46080, 0) - 23040);
      default: begin
        b = c.roll_smooth_band;
        t.roll = 16'(roll_goal + longint'($urandom_range(2 * b + 4, 0)) - (b + 2));
      end
    endcase
    case ($urandom_range(3, 0))
      0: t.pitch = 16'($urandom);
      1: t.pitch = 16'($urandom_range(46080, 0) - 23040);
      default: t.pitch = 16'(longint'($signed(c.target_slope))
                             + longint'($urandom_range(2 * GLIDE_BAND + 4, 0))
                             - (GLIDE_BAND + 2));
    endcase
    return t;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write every register; unused upper data bits carry random junk
  task automatic load_settings(input cfg_t c);
    write_reg(REG_MODE, {14'($urandom), c.mode});
    write_reg(REG_TARGET_HEADING, c.target_heading);
    write_reg(REG_ROLL_OUT_BAND, {1'($urandom), c.roll_out_band});
    write_reg(REG_MAX_ROLL, {1'($urandom), c.max_roll});
    write_reg(REG_MAX_AILERON, {1'($urandom), c.max_aileron});
    write_reg(REG_ROLL_SMOOTH_BAND, {1'($urandom), c.roll_smooth_band});
    write_reg(REG_TARGET_SLOPE, {1'($urandom), c.target_slope});
    write_reg(REG_MAX_ELEVATOR, {1'($urandom), c.max_elevator});
    cfg_we <= 1'b0;
    ap_cfg = c;
    settings_loaded++;
  endtask

  // Offer one request after a random gap; record its expected result on acceptance
  task automatic send_tick(input tick_t t, input bit given, input ctl_t want);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(12, 0);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.heading <= t.heading;
    sample_ch.roll    <= t.roll;
    sample_ch.pitch   <= t.pitch;
    do @(posedge clk); while (!sample_ch.ready);
    pending_cmds.push_back(given ? want : predict_hold(ap_cfg, t));
    ticks_by_mode[ap_cfg.mode]++;
  endtask

  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off, in-order compare
  initial begin : result_sink
    int   stall;
    bit   held;
    ctl_t want;
    held = 1'b0;
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_checked == HOLD_AT) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = rx_calm ? 0 : $urandom_range(12, 0);
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing pending", results_checked);
      end else begin
        want = pending_cmds.pop_front();
        if (result_ch.surface !== want.surface || result_ch.command !== want.command ||
            result_ch.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d: expected surface %0d command %0d status %0d,",
                     results_checked, want.surface, want.command, want.status);
            $display("  got surface %0d command %0d status %0d",
                     result_ch.surface, result_ch.command, result_ch.status);
          end
        end
      end
      results_checked++;
    end
  end

  // Stimulus: directed table, then random phases with fresh settings each
  initial begin : stimulus
    int   cur_preset;
    int   phase;
    int   random_sent;
    int   n;
    ctl_t none;
    sample_ch.valid   = 1'b0;
    sample_ch.heading = '0;
    sample_ch.roll    = '0;
    sample_ch.pitch   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_MODE;
    cfg_data  = '0;
    none = '0;

    presets[P_OFF]       = make_cfg(MODE_OFF, 0, 3840, 896, 3277, 1280, 0, 0);
    presets[P_INVALID]   = make_cfg(MODE_INVALID, 0, 3840, 896, 3277, 1280, 0, 0);
    presets[P_HEAD]      = make_cfg(MODE_HEADING, 0, 3840, 896, 3277, 1280, 0, 0);
    presets[P_HEAD_EXT]  = make_cfg(MODE_HEADING, 46079, 1, 23040, 32767, 1, 0, 0);
    presets[P_ZERO_BAND] = make_cfg(MODE_HEADING, 100, 0, 23040, 32767, 0, 0, 0);
    presets[P_GLIDE]     = make_cfg(MODE_GLIDE, 0, 3840, 896, 3277, 1280, 0, 32767);
    presets[P_GLIDE_NEG] = make_cfg(MODE_GLIDE, 0, 3840, 896, 3277, 1280, -11520, 16384);

    // mode off straight after reset, and invalid mode
    add_row(P_OFF, 0, 0, 0, 1, SURF_NONE, 0, STAT_OK);
    add_row(P_OFF, 65535, -32768, 32767, 1, SURF_NONE, 0, STAT_OK);
    add_row(P_INVALID, 0, 0, 0, 1, SURF_NONE, 0, STAT_INVALID);
    add_row(P_INVALID, 46079, 23040, -23040, 1, SURF_NONE, 0, STAT_INVALID);
    // heading hold at reset gains: wrap at 180 degrees, band edge, roll extremes
    add_row(P_HEAD, 0, 0, 0, 1, SURF_AILERON, 0, STAT_OK);
    add_row(P_HEAD, 23040, 896, 0, 1, SURF_AILERON, 0, STAT_OK);
    add_row(P_HEAD, 23041, 0, 0, 0, SURF_NONE, 0, STAT_OK);
    add_row(P_HEAD, 3840, 0, 0, 0, SURF_NONE, 0, STAT_OK);
    add_row(P_HEAD, 3841, 0, 0, 0, SURF_NONE, 0, STAT_OK);
    add_row(P_HEAD, 0, 32767, 0, 0, SURF_NONE, 0, STAT_OK);
    add_row(P_HEAD, 0, -32768, 0, 0, SURF_NONE, 0, STAT_OK);
    add_row(P_HEAD, 65535, 0, 0, 0, SURF_NONE, 0, STAT_OK);
    // unit bands with largest gains
    add_row(P_HEAD_EXT, 0, 0, 0, 0, SURF_NONE, 0, STAT_OK);
    add_row(P_HEAD_EXT, 46079, 0, 0, 1, SURF_AILERON, 0, STAT_OK);
    add_row(P_HEAD_EXT, 46078, -23040, 0, 0, SURF_NONE, 0, STAT_OK);
    // zero bands: zero error gives zero, anything else saturates
    add_row(P_ZERO_BAND, 100, 0, 0, 1, SURF_AILERON, 0, STAT_OK);
    add_row(P_ZERO_BAND, 100, 1, 0, 1, SURF_AILERON, -32767, STAT_OK);
    add_row(P_ZERO_BAND, 101, 0, 0, 0, SURF_NONE, 0, STAT_OK);
    // glide slope: fixed band edge and pitch extremes
    add_row(P_GLIDE, 0, 0, 0, 1, SURF_ELEVATOR, 0, STAT_OK);
    add_row(P_GLIDE, 0, 0, 1280, 0, SURF_NONE, 0, STAT_OK);
    add_row(P_GLIDE, 0, 0, -1281, 0, SURF_NONE, 0, STAT_OK);
    add_row(P_GLIDE, 0, 0, -32768, 0, SURF_NONE, 0, STAT_OK);
    add_row(P_GLIDE_NEG, 0, 0, -11520, 1, SURF_ELEVATOR, 0, STAT_OK);
    add_row(P_GLIDE_NEG, 0, 0, 32767, 0, SURF_NONE, 0, STAT_OK);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    cur_preset = P_OFF;
    ap_cfg = presets[P_OFF];
    foreach (dir_rows[k]) begin
      if (dir_rows[k].preset != cur_preset) begin
        drain_results();
        load_settings(presets[dir_rows[k].preset]);
        cur_preset = dir_rows[k].preset;
      end
      send_tick(dir_rows[k].tick, dir_rows[k].given, dir_rows[k].want);
    end

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_TICKS) begin
      drain_results();
      load_settings(random_settings(phase));
      tx_calm = (phase % 5 == 3) || ($urandom_range(3, 0) == 0);
      rx_calm = (phase % 5 == 3) || ($urandom_range(3, 0) == 0);
      n = $urandom_range(130, 60);
      repeat (n) begin
        send_tick(random_tick(ap_cfg), 1'b0, none);
        random_sent++;
      end
      phase++;
    end

    drain_results();
    repeat (60) @(posedge clk);

    $display("Checked %0d control results over %0d register settings.",
             results_checked, settings_loaded);
    $display("Ticks by mode: off %0d, heading hold %0d, glide slope %0d, invalid %0d.",
             ticks_by_mode[MODE_OFF], ticks_by_mode[MODE_HEADING],
             ticks_by_mode[MODE_GLIDE], ticks_by_mode[MODE_INVALID]);
    if (pending_cmds.size() != 0)
      $display("%0d expected results never arrived", pending_cmds.size());
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("autopilot_saturated_hold verification clean");
    end else begin
      $display("%0d result mismatches", mismatches);
      $display("autopilot_saturated_hold verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("autopilot_saturated_hold verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/aph_pkg.sv
hw/rtl/aph_if.sv
hw/rtl/aph_shape.sv
hw/rtl/autopilot_saturated_hold.sv
hw/rtl/aph_check.sv
tb/tb_autopilot_saturated_hold.sv
